// ----- rtl/register_machine_execute_top_assert.svh -----
// Assertion macros for the execute block checker.
`ifndef REGISTER_MACHINE_EXECUTE_TOP_ASSERT_SVH
`define REGISTER_MACHINE_EXECUTE_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define RME_ASSERT_IMP(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
// Next-cycle implication.
`define RME_ASSERT_NXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`endif

// ----- rtl/rme_pkg.sv -----
// ----------------------------------------------------------------------------
// rme_pkg
// Opcodes, error codes and shared types of the register machine execute block.
// ----------------------------------------------------------------------------
`default_nettype none
package rme_pkg;
    localparam logic [4:0] OP_ADD  = 5'd0;
    localparam logic [4:0] OP_SUB  = 5'd1;
    localparam logic [4:0] OP_MUL  = 5'd2;
    localparam logic [4:0] OP_DIV  = 5'd3;
    localparam logic [4:0] OP_AND  = 5'd4;
    localparam logic [4:0] OP_OR   = 5'd5;
    localparam logic [4:0] OP_XOR  = 5'd6;
    localparam logic [4:0] OP_SHL  = 5'd7;
    localparam logic [4:0] OP_SHR  = 5'd8;
    localparam logic [4:0] OP_SLT  = 5'd9;
    localparam logic [4:0] OP_SLE  = 5'd10;
    localparam logic [4:0] OP_SEQ  = 5'd11;
    localparam logic [4:0] OP_LOAD = 5'd12;
    localparam logic [4:0] OP_STOR = 5'd13;
    localparam logic [4:0] OP_JAL  = 5'd14;
    localparam logic [4:0] OP_BZ   = 5'd15;
    localparam logic [4:0] OP_BNZ  = 5'd16;
    localparam logic [4:0] OP_CON  = 5'd17;
    localparam logic [4:0] OP_STOP = 5'd18;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_OP   = 2'd1;
    localparam logic [1:0] ERR_DIV0 = 2'd2;
    localparam logic [1:0] ERR_IDX  = 2'd3;

    localparam int PC_W   = 16;
    localparam int CON_W  = 32;
    localparam int IN_W   = 64;   // 5+5+1+16+5+32 bits
    localparam int OUT_W  = 56;   // 16+1+1+32+2 padded to bytes

    // divider control handed between top level and divider
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;
endpackage
`default_nettype wire

// ----- rtl/register_machine_execute_top.sv -----
// ----------------------------------------------------------------------------
// register_machine_execute_top
// Executes one decoded instruction per transaction against a register file.
// ----------------------------------------------------------------------------
// An instruction enters on the s_axis channel and yields exactly one result
// transaction on m_axis (next pc, halted, console output, error code). The
// register file is a synchronous RAM with registered read data and one read
// port, so operands are fetched in turn: an ordinary instruction reads its
// operand and reg_a, executes and outputs; a multiply adds a multiply step, a
// store ends after the indexed read and memory steps, a load goes on to the
// output, and a divide waits on the bit-serial divider. A console read answers
// from the register 1 read, a console write from the console state; a stop,
// a decode error or any instruction after stop answers from idle. After reset
// a clearing pass zeroes every register, during which no instruction is
// accepted. One instruction is in flight at a time; the next is accepted only
// once the previous result is taken, or is being taken in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module register_machine_execute_top #(
    parameter int REG_COUNT  = 32,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    // func[4:0], reg_a[9:5], operand_is_register[10], operand[26:11],
    // reg_b[31:27], keyboard_value[63:32]
    input  wire logic [rme_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // next_pc[15:0], halted[16], console_valid[17], console_value[49:18],
    // error_code[51:50], zero fill[55:52]
    output logic      [rme_pkg::OUT_W-1:0]  m_axis_tdata
);
    import rme_pkg::*;

    localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int SW = $clog2(DATA_WIDTH + 1);

    localparam logic [3:0] ST_CLR  = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_RDO  = 4'd2;  // operand register read issued
    localparam logic [3:0] ST_RDA  = 4'd3;  // reg_a read issued
    localparam logic [3:0] ST_EXE  = 4'd4;  // reg_a data present
    localparam logic [3:0] ST_RDX  = 4'd5;  // indexed read issued (load/store)
    localparam logic [3:0] ST_MEM  = 4'd6;
    localparam logic [3:0] ST_DIV  = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;
    localparam logic [3:0] ST_RD1  = 4'd9;  // register 1 read for console
    localparam logic [3:0] ST_CON  = 4'd10;
    localparam logic [3:0] ST_MUL  = 4'd11;

    logic [3:0]            state_reg, state_next;
    logic [AW-1:0]         clr_reg, clr_next;
    logic [PC_W-1:0]       pc_reg, pc_next;
    logic                  stop_reg, stop_next;

    // latched instruction
    logic [4:0]            func_reg;
    logic [4:0]            ra_reg, rb_reg;
    logic                  isreg_reg;
    logic [15:0]           opnd_reg;
    logic [31:0]           kb_reg;
    logic [DATA_WIDTH-1:0] ov_reg, ov_next;
    logic [DATA_WIDTH-1:0] av_reg, av_next;
    logic [DATA_WIDTH-1:0] res_reg, res_next;
    logic [DATA_WIDTH-1:0] idx_reg, idx_next;

    logic                  ovalid_reg, ovalid_next;
    logic [OUT_W-1:0]      odata_reg, odata_next;

    // RAM port
    logic                  we;
    logic [AW-1:0]         waddr, raddr;
    logic [DATA_WIDTH-1:0] wdata, rdata;

    div_ctl_t              dctl;
    logic [DATA_WIDTH-1:0] quot;
    logic                  div_start;

    // input fields
    logic [4:0]  in_func, in_ra, in_rb;
    logic        in_isreg;
    logic [15:0] in_opnd;
    logic        accept;
    logic        uses_a, uses_b, uses_o;
    logic [1:0]  dec_err;

    // execute signals
    logic [DATA_WIDTH-1:0] opnd_ext;
    logic [DATA_WIDTH-1:0] sh_res;
    logic                  a_lt, a_eq;
    logic [DATA_WIDTH-1:0] cval;

    assign in_func  = s_axis_tdata[4:0];
    assign in_ra    = s_axis_tdata[9:5];
    assign in_isreg = s_axis_tdata[10];
    assign in_opnd  = s_axis_tdata[26:11];
    assign in_rb    = s_axis_tdata[31:27];

    assign s_axis_tready = (state_reg == ST_IDLE) && (!ovalid_reg || m_axis_tready);
    assign accept = s_axis_tvalid && s_axis_tready;

    assign opnd_ext = (DATA_WIDTH >= 16) ? DATA_WIDTH'({{(64-16){1'b0}}, opnd_reg})
                                         : DATA_WIDTH'(opnd_reg);

    // decode-time checks, based on the incoming instruction
    always_comb
    begin
        uses_o = (in_func <= OP_BNZ);
        uses_a = (in_func <= OP_STOR) || (in_func == OP_BZ) || (in_func == OP_BNZ);
        uses_b = (in_func <= OP_JAL);
        dec_err = ERR_NONE;
        if (in_func > OP_STOP)
        begin
            dec_err = ERR_OP;
        end
        else if ((uses_a && 32'(in_ra) >= REG_COUNT) || (uses_b && 32'(in_rb) >= REG_COUNT)
                 || (uses_o && in_isreg && 32'(in_opnd) >= REG_COUNT))
        begin
            dec_err = ERR_IDX;
        end
    end

    // shifts and compares
    always_comb
    begin
        if (ov_reg >= DATA_WIDTH'(DATA_WIDTH))
        begin
            sh_res = (func_reg == OP_SHL) ? '0 : {DATA_WIDTH{av_reg[DATA_WIDTH-1]}};
        end
        else if (func_reg == OP_SHL)
        begin
            sh_res = av_reg << ov_reg[SW-1:0];
        end
        else
        begin
            sh_res = DATA_WIDTH'($signed(av_reg) >>> ov_reg[SW-1:0]);
        end
        a_lt = $signed(av_reg) < $signed(ov_reg);
        a_eq = (av_reg == ov_reg);
    end

    function automatic logic [OUT_W-1:0] pack_out(input logic [PC_W-1:0] npc,
                                                  input logic hlt, input logic cv,
                                                  input logic [31:0] cvv,
                                                  input logic [1:0] err);
        pack_out = {4'b0, err, cvv, cv, hlt, npc};
    endfunction

    always_comb
    begin
        cval = DATA_WIDTH'(0);
        if (DATA_WIDTH >= 32)
        begin
            cval = rdata;
        end
        else
        begin
            cval = rdata;
        end
    end

    logic [31:0] con_out;
    logic [DATA_WIDTH-1:0] kb_ext;
    assign con_out = 32'($signed(cval));
    assign kb_ext  = DATA_WIDTH'($signed(kb_reg));

    logic [AW-1:0] idx_a;
    assign idx_a = idx_reg[AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        clr_next = clr_reg;
        pc_next = pc_reg;
        stop_next = stop_reg;
        ov_next = ov_reg;
        av_next = av_reg;
        res_next = res_reg;
        idx_next = idx_reg;
        ovalid_next = ovalid_reg;
        odata_next = odata_reg;
        we = 1'b0;
        waddr = rb_reg[AW-1:0];
        wdata = res_reg;
        raddr = ra_reg[AW-1:0];
        div_start = 1'b0;
        if (ovalid_reg && m_axis_tready)
        begin
            ovalid_next = 1'b0;
        end
        case (state_reg)
            ST_CLR:
            begin
                we = 1'b1;
                waddr = clr_reg;
                wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == REG_COUNT - 1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                raddr = in_opnd[AW-1:0];
                if (accept)
                begin
                    ovalid_next = 1'b0;
                    if (stop_reg)
                    begin
                        ovalid_next = 1'b1;
                        odata_next = pack_out(pc_reg, 1'b1, 1'b0, '0, ERR_NONE);
                    end
                    else if (dec_err != ERR_NONE)
                    begin
                        ovalid_next = 1'b1;
                        odata_next = pack_out(pc_reg, 1'b0, 1'b0, '0, dec_err);
                    end
                    else if (in_func == OP_STOP)
                    begin
                        stop_next = 1'b1;
                        ovalid_next = 1'b1;
                        odata_next = pack_out(pc_reg, 1'b1, 1'b0, '0, ERR_NONE);
                    end
                    else if (in_func == OP_CON)
                    begin
                        state_next = ST_RD1;
                    end
                    else
                    begin
                        state_next = ST_RDO;
                    end
                end
            end
            ST_RDO:
            begin
                // rdata holds register[operand]
                ov_next = isreg_reg ? rdata : opnd_ext;
                raddr = ra_reg[AW-1:0];
                state_next = ST_RDA;
            end
            ST_RDA:
            begin
                av_next = rdata;
                state_next = ST_EXE;
            end
            ST_EXE:
            begin
                res_next = '0;
                state_next = ST_OUT;
                case (func_reg)
                    OP_ADD: res_next = av_reg + ov_reg;
                    OP_SUB: res_next = av_reg - ov_reg;
                    OP_MUL: state_next = ST_MUL;
                    OP_DIV:
                    begin
                        if (ov_reg == '0)
                        begin
                            ovalid_next = 1'b1;
                            odata_next = pack_out(pc_reg, 1'b0, 1'b0, '0, ERR_DIV0);
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            div_start = 1'b1;
                            state_next = ST_DIV;
                        end
                    end
                    OP_AND: res_next = av_reg & ov_reg;
                    OP_OR:  res_next = av_reg | ov_reg;
                    OP_XOR: res_next = av_reg ^ ov_reg;
                    OP_SHL, OP_SHR: res_next = sh_res;
                    OP_SLT: res_next = DATA_WIDTH'(a_lt);
                    OP_SLE: res_next = DATA_WIDTH'(a_lt || a_eq);
                    OP_SEQ: res_next = DATA_WIDTH'(a_eq);
                    OP_LOAD, OP_STOR:
                    begin
                        idx_next = DATA_WIDTH'(ra_reg) + ov_reg;
                        state_next = ST_RDX;
                    end
                    OP_JAL: res_next = DATA_WIDTH'(pc_reg + 1'b1);
                    default: res_next = '0;
                endcase
            end
            ST_MUL:
            begin
                res_next = av_reg * ov_reg;
                state_next = ST_OUT;
            end
            ST_DIV:
            begin
                if (dctl.done)
                begin
                    res_next = quot;
                    state_next = ST_OUT;
                end
            end
            ST_RDX:
            begin
                if (idx_reg >= DATA_WIDTH'(REG_COUNT))
                begin
                    ovalid_next = 1'b1;
                    odata_next = pack_out(pc_reg, 1'b0, 1'b0, '0, ERR_IDX);
                    state_next = ST_IDLE;
                end
                else
                begin
                    // load reads idx, store reads the source register
                    raddr = (func_reg == OP_LOAD) ? idx_a : rb_reg[AW-1:0];
                    state_next = ST_MEM;
                end
            end
            ST_MEM:
            begin
                if (func_reg == OP_LOAD)
                begin
                    res_next = rdata;
                    state_next = ST_OUT;
                end
                else
                begin
                    we = 1'b1;
                    waddr = idx_a;
                    wdata = rdata;
                    pc_next = pc_reg + 1'b1;
                    ovalid_next = 1'b1;
                    odata_next = pack_out(pc_reg + 1'b1, 1'b0, 1'b0, '0, ERR_NONE);
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                ovalid_next = 1'b1;
                state_next = ST_IDLE;
                case (func_reg)
                    OP_BZ, OP_BNZ:
                    begin
                        if ((av_reg == '0) == (func_reg == OP_BZ))
                        begin
                            pc_next = ov_reg[PC_W-1:0];
                        end
                        else
                        begin
                            pc_next = pc_reg + 1'b1;
                        end
                    end
                    OP_JAL:
                    begin
                        pc_next = ov_reg[PC_W-1:0];
                        we = 1'b1;
                    end
                    default:
                    begin
                        pc_next = pc_reg + 1'b1;
                        we = 1'b1;
                    end
                endcase
                odata_next = pack_out(pc_next, 1'b0, 1'b0, '0, ERR_NONE);
            end
            ST_RD1:
            begin
                raddr = AW'(1);
                state_next = ST_CON;
                if (!isreg_reg)
                begin
                    we = 1'b1;
                    waddr = AW'(1);
                    wdata = kb_ext;
                    pc_next = pc_reg + 1'b1;
                    ovalid_next = 1'b1;
                    odata_next = pack_out(pc_reg + 1'b1, 1'b0, 1'b0, '0, ERR_NONE);
                    state_next = ST_IDLE;
                end
            end
            ST_CON:
            begin
                pc_next = pc_reg + 1'b1;
                ovalid_next = 1'b1;
                odata_next = pack_out(pc_reg + 1'b1, 1'b0, 1'b1, con_out, ERR_NONE);
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    rme_ram #(
        .WIDTH(DATA_WIDTH),
        .DEPTH(REG_COUNT)
    ) u_rf (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    rme_div #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(av_reg),
        .divisor (ov_reg),
        .ctl     (dctl),
        .quotient(quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
            clr_reg <= '0;
            pc_reg <= '0;
            stop_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            pc_reg <= pc_next;
            stop_reg <= stop_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= in_func;
            ra_reg <= in_ra;
            rb_reg <= in_rb;
            isreg_reg <= in_isreg;
            opnd_reg <= in_opnd;
            kb_reg <= s_axis_tdata[63:32];
        end
        ov_reg <= ov_next;
        av_reg <= av_next;
        res_reg <= res_next;
        idx_reg <= idx_next;
        odata_reg <= odata_next;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = odata_reg;
endmodule
`default_nettype wire

// ----- rtl/rme_ram.sv -----
// ----------------------------------------------------------------------------
// rme_ram
// Generic single-port-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module rme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/rme_div.sv -----
// ----------------------------------------------------------------------------
// rme_div
// Signed truncating divider, restoring, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module rme_div #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DATA_WIDTH-1:0] dividend,
    input  wire logic [DATA_WIDTH-1:0] divisor,
    output rme_pkg::div_ctl_t          ctl,
    output logic      [DATA_WIDTH-1:0] quotient
);
    import rme_pkg::*;
    localparam int CW = $clog2(DATA_WIDTH + 1);

    logic [DATA_WIDTH-1:0] q_reg, q_next;
    logic [DATA_WIDTH:0]   r_reg, r_next;
    logic [DATA_WIDTH-1:0] d_reg, d_next;
    logic                  neg_reg, neg_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH:0]   shifted;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted = {r_reg[DATA_WIDTH-1:0], q_reg[DATA_WIDTH-1]};
        trial = shifted - {1'b0, d_reg};
        if (start)
        begin
            // magnitudes; most negative maps to its own pattern as unsigned
            q_next = dividend[DATA_WIDTH-1] ? (~dividend + 1'b1) : dividend;
            d_next = divisor[DATA_WIDTH-1] ? (~divisor + 1'b1) : divisor;
            neg_next = dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
            r_next = '0;
            cnt_next = CW'(DATA_WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DATA_WIDTH])
            begin
                r_next = trial;
                q_next = {q_reg[DATA_WIDTH-2:0], 1'b1};
            end
            else
            begin
                r_next = shifted;
                q_next = {q_reg[DATA_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        neg_reg <= neg_next;
    end

    assign quotient = neg_reg ? (~q_reg + 1'b1) : q_reg;
    assign ctl.start = start;
    assign ctl.busy = busy_reg;
    assign ctl.done = done_reg;
endmodule
`default_nettype wire

// ----- rtl/rme_checker.sv -----
// ----------------------------------------------------------------------------
// rme_checker
// Port-level checks of the execute block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "register_machine_execute_top_assert.svh"
module rme_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [55:0] m_axis_tdata
);
    // a held result stays put
    `RME_ASSERT_NXT(a_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata),
        "result changed while stalled")
    // a result right after a halted one also reports halted
    `RME_ASSERT_NXT(a_halt, m_axis_tvalid && m_axis_tready && m_axis_tdata[16],
        !m_axis_tvalid || m_axis_tdata[16], "halted flag dropped")
    // console output only without an error
    `RME_ASSERT_IMP(a_con, m_axis_tvalid && m_axis_tdata[17],
        m_axis_tdata[51:50] == 2'd0, "console output with error")
    // no new instruction while a stalled result waits
    `RME_ASSERT_IMP(a_rdy, m_axis_tvalid && !m_axis_tready, !s_axis_tready,
        "accepted while result stalled")
endmodule

bind register_machine_execute_top rme_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);
`default_nettype wire

// ----- sim/register_machine_execute_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// register_machine_execute_top_tb
// Self-checking bench: drives decoded instructions, predicts every result
// transaction with an in-bench machine model and compares field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module register_machine_execute_top_tb;
    import rme_pkg::*;

    localparam int NREG = 32;
    localparam int LIMIT_CYCLES = 1500000;

    typedef struct packed {
        logic [31:0] kb;
        logic [4:0]  rb;
        logic [15:0] opnd;
        logic        isreg;
        logic [4:0]  ra;
        logic [4:0]  func;
    } instr_t;

    typedef struct packed {
        logic [1:0]  err;
        logic [31:0] cval;
        logic        cvalid;
        logic        halted;
        logic [15:0] npc;
    } outcome_t;

    // ------------------------------------------------------------------------
    // Scoreboard: machine model plus queue of pending outcomes.
    // ------------------------------------------------------------------------
    class exec_scoreboard;
        logic [31:0] regs [NREG];
        logic [15:0] pc;
        bit          stopped;
        outcome_t    pending [$];
        int          errors;
        int          checked;

        function new();
            foreach (regs[i]) regs[i] = '0;
            pc = '0;
            stopped = 0;
            errors = 0;
            checked = 0;
        endfunction

        function void note_instr(instr_t ins);
            outcome_t o;
            logic [31:0] ov, av, res, q, ma, mb;
            logic [15:0] pc1;
            logic [1:0] err;
            bit ua, ub, uo;
            logic [31:0] idx;
            o = '0;
            pc1 = pc + 16'd1;
            ov = '0; av = '0; res = '0; idx = '0; err = ERR_NONE;
            if (stopped) begin
                o.npc = pc;
                o.halted = 1'b1;
                pending.push_back(o);
                return;
            end
            if (ins.func > OP_STOP) err = ERR_OP;
            else begin
                uo = ins.func <= OP_BNZ;
                ua = ins.func <= OP_STOR || ins.func == OP_BZ || ins.func == OP_BNZ;
                ub = ins.func <= OP_JAL;
                if ((ua && ins.ra >= NREG) || (ub && ins.rb >= NREG)
                    || (uo && ins.isreg && ins.opnd >= NREG))
                    err = ERR_IDX;
            end
            if (err == ERR_NONE) begin
                if (uo) ov = ins.isreg ? regs[ins.opnd[4:0]] : {16'd0, ins.opnd};
                if (ua) av = regs[ins.ra];
                if (ins.func == OP_DIV && ov == 0) err = ERR_DIV0;
                if (ins.func == OP_LOAD || ins.func == OP_STOR) begin
                    idx = {27'd0, ins.ra} + ov;
                    if (idx >= NREG) err = ERR_IDX;
                end
            end
            o.npc = pc;
            if (err == ERR_NONE) begin
                o.npc = pc1;
                case (ins.func)
                    OP_ADD: res = av + ov;
                    OP_SUB: res = av - ov;
                    OP_MUL: res = av * ov;
                    OP_DIV: begin
                        ma = av[31] ? -av : av;
                        mb = ov[31] ? -ov : ov;
                        q = ma / mb;
                        res = (av[31] != ov[31]) ? -q : q;
                    end
                    OP_AND: res = av & ov;
                    OP_OR:  res = av | ov;
                    OP_XOR: res = av ^ ov;
                    OP_SHL: res = (ov >= 32) ? '0 : av << ov[4:0];
                    OP_SHR: begin
                        if (ov >= 32) res = {32{av[31]}};
                        else res = $signed(av) >>> ov[4:0];
                    end
                    OP_SLT: res = ($signed(av) < $signed(ov)) ? 1 : 0;
                    OP_SLE: res = ($signed(av) <= $signed(ov)) ? 1 : 0;
                    OP_SEQ: res = (av == ov) ? 1 : 0;
                    OP_LOAD: res = regs[idx[4:0]];
                    OP_STOR: regs[idx[4:0]] = regs[ins.rb];
                    OP_JAL: begin
                        res = {16'd0, pc1};
                        o.npc = ov[15:0];
                    end
                    OP_BZ:  o.npc = (av == 0) ? ov[15:0] : pc1;
                    OP_BNZ: o.npc = (av != 0) ? ov[15:0] : pc1;
                    OP_CON: begin
                        if (!ins.isreg) regs[1] = ins.kb;
                        else begin
                            o.cvalid = 1'b1;
                            o.cval = regs[1];
                        end
                    end
                    default: begin
                        stopped = 1;
                        o.npc = pc;
                    end
                endcase
                if (ins.func <= OP_LOAD || ins.func == OP_JAL) regs[ins.rb] = res;
                pc = o.npc;
            end
            o.halted = stopped;
            o.err = err;
            pending.push_back(o);
        endfunction

        function void check_result(outcome_t got);
            outcome_t w;
            checked++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (got.npc !== w.npc)
                $display("%0t: next_pc exp %h got %h", $time, w.npc, got.npc);
            if (got.halted !== w.halted)
                $display("%0t: halted exp %b got %b", $time, w.halted, got.halted);
            if (got.cvalid !== w.cvalid)
                $display("%0t: console_valid exp %b got %b", $time, w.cvalid, got.cvalid);
            if (got.cval !== w.cval)
                $display("%0t: console_value exp %h got %h", $time, w.cval, got.cval);
            if (got.err !== w.err)
                $display("%0t: error_code exp %0d got %0d", $time, w.err, got.err);
            if (got !== w) errors++;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;

    exec_scoreboard sb;
    int  send_idle_pct;    // sender gap odds per cycle
    int  recv_stall_pct;   // receiver stall odds per cycle
    bit  hold_recv;        // forced long receiver hold-off
    int  n_sent;
    longint cycles;

    register_machine_execute_top #(.REG_COUNT(32), .DATA_WIDTH(32)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: one process counts cycles and ends a hung run.
    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT_CYCLES) begin
                $display("timeout after %0d cycles", cycles);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Receiver: random stalls, or fully held while hold_recv is set.
    // Results are sampled on the edge where the transaction completes.
    always @(posedge clk) begin
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(outcome_t'(m_axis_tdata[51:0]));
            m_axis_tready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Send one instruction; the transaction completes on the edge where
    // tready is seen high with tvalid. Gaps come in front of the item, so
    // with no idling items follow back to back.
    task automatic send_instr(instr_t ins);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ins;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_instr(ins);
        n_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    function automatic instr_t mk(logic [4:0] f, logic [4:0] a, logic r,
                                  logic [15:0] o, logic [4:0] b, logic [31:0] k);
        instr_t i;
        i.func = f; i.ra = a; i.isreg = r; i.opnd = o; i.rb = b; i.kb = k;
        return i;
    endfunction

    // Mostly legal instructions over small register numbers and operands
    // that land in range, with some fully random noise.
    function automatic instr_t rand_instr();
        instr_t i;
        int sel;
        i = instr_t'({$urandom, $urandom});
        sel = $urandom_range(99);
        if (sel < 85) begin
            i.func = $urandom_range(17);
            if ($urandom_range(9) == 0) i.func = OP_STOP;
            if (i.func == OP_STOP && $urandom_range(3) != 0) i.func = OP_ADD;
            if (i.isreg || $urandom_range(2) == 0) i.opnd = $urandom_range(31);
            if ((i.func == OP_LOAD || i.func == OP_STOR) && !i.isreg)
                i.opnd = $urandom_range(31 - i.ra);
            if (i.func == OP_SHL || i.func == OP_SHR)
                if (!i.isreg) i.opnd = $urandom_range(40);
        end
        return i;
    endfunction

    initial begin
        instr_t i;
        sb = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        hold_recv = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        n_sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: console read of the most negative value, every op but stop, errors, overflow.
        send_instr(mk(OP_CON, 0, 0, 0, 0, 32'h8000_0000));
        send_instr(mk(OP_ADD, 1, 0, 16'hFFFF, 2, 0));          // r2 = min + 0xffff
        send_instr(mk(OP_SUB, 0, 0, 1, 3, 0));                 // r3 = -1
        send_instr(mk(OP_DIV, 1, 1, 3, 4, 0));                 // min / -1 wraps
        send_instr(mk(OP_DIV, 1, 0, 0, 4, 0));                 // divide by zero
        send_instr(mk(OP_MUL, 3, 1, 2, 5, 0));
        send_instr(mk(OP_AND, 3, 0, 16'hA5A5, 6, 0));
        send_instr(mk(OP_OR,  1, 1, 2, 7, 0));
        send_instr(mk(OP_XOR, 3, 1, 1, 8, 0));
        send_instr(mk(OP_SHL, 3, 0, 32, 9, 0));                // shift of width
        send_instr(mk(OP_SHR, 1, 0, 40, 9, 0));                // sign fill
        send_instr(mk(OP_SHR, 1, 0, 31, 10, 0));
        send_instr(mk(OP_SLT, 1, 0, 0, 11, 0));
        send_instr(mk(OP_SLE, 3, 1, 3, 12, 0));
        send_instr(mk(OP_SEQ, 3, 1, 3, 13, 0));
        send_instr(mk(OP_STOR, 31, 0, 0, 3, 0));
        send_instr(mk(OP_LOAD, 31, 0, 0, 14, 0));
        send_instr(mk(OP_LOAD, 31, 0, 1, 14, 0));              // index overflow
        send_instr(mk(OP_LOAD, 0, 1, 3, 14, 0));               // index of -1 out of range
        send_instr(mk(OP_JAL, 0, 0, 16'hFFFF, 15, 0));
        send_instr(mk(OP_BZ, 0, 0, 16'h1234, 0, 0));
        send_instr(mk(OP_BNZ, 3, 0, 16'h0042, 0, 0));
        send_instr(mk(OP_ADD, 0, 1, 16'h8000, 1, 0));          // bad register operand
        send_instr(mk(5'd31, 0, 0, 0, 0, 0));                  // bad opcode
        send_instr(mk(OP_CON, 0, 1, 0, 0, 32'h7FFF_FFFF));     // console write
        wait_drained();

        // Random phases over the idling mixes; a stop may end the machine's
        // work, after which results just repeat the halted state.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                3: begin send_idle_pct = 32; recv_stall_pct = 32; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (ph == 4) begin
                // Long receiver hold-off while the sender keeps offering.
                fork
                    begin
                        hold_recv = 1;
                        repeat (400) @(posedge clk);
                        hold_recv = 0;
                    end
                join_none
            end
            for (int k = 0; k < 275; k++) begin
                i = rand_instr();
                // Keep the machine alive throughout the early phases.
                if (i.func == OP_STOP && ph < 3) i.func = OP_SEQ;
                send_instr(i);
            end
            // Sender pauses until every pending result has come.
            wait_drained();
        end

        $display("ran %0d instructions, %0d results checked over 5 idling phases",
                 n_sent, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire

// ----- filelist.f -----
+incdir+rtl
rtl/rme_pkg.sv
rtl/rme_ram.sv
rtl/rme_div.sv
rtl/register_machine_execute_top.sv
rtl/rme_checker.sv
sim/register_machine_execute_top_tb.sv
